// ----- rtl/jsu_pkg.sv -----
// Shared types and codes for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ZERO    = 2'd1;
    localparam logic [1:0] ERR_ESCAPE  = 2'd2;
    localparam logic [1:0] ERR_BAD_HEX = 2'd3;

    // One queued job: up to three results caused by one input byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_kind      kind;
        logic [1:0] code;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_job;

endpackage
`default_nettype wire

// ----- rtl/jsu_front.sv -----
// Front end: accepts raw bytes, tracks the decode mode and builds result jobs.
`timescale 1ns / 1ps
`default_nettype none
module jsu_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_tvalid,
    output logic             o_tready,
    input  wire  [7:0]       i_byte,
    input  wire              i_restart,
    input  wire              i_full,
    output logic             o_push,
    output jsu_pkg::t_job    o_job
);
    import jsu_pkg::*;

    typedef enum logic [7:0] {
        M_PLAIN = 8'b0000_0001,
        M_ESC   = 8'b0000_0010,
        M_HEX1  = 8'b0000_0100,
        M_HEX2  = 8'b0000_1000,
        M_HEX3  = 8'b0001_0000,
        M_HEX4  = 8'b0010_0000,
        M_ERROR = 8'b0100_0000,
        M_DONE  = 8'b1000_0000
    } t_mode;

    t_mode       r_mode, n_mode, mode_eff;
    logic [15:0] r_acc, n_acc, acc_eff, cp;
    logic [3:0]  digit;
    logic        is_hex;
    logic [7:0]  esc_byte;
    logic        accept;

    always_comb begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            digit = i_byte[3:0];
        end else if (i_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            digit = 4'(i_byte[2:0] + 4'd9);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        case (i_byte)
            8'h2F:   esc_byte = 8'h2F;
            8'h5C:   esc_byte = 8'h5C;
            8'h22:   esc_byte = 8'h22;
            8'h74:   esc_byte = 8'h09;
            8'h6E:   esc_byte = 8'h0A;
            8'h62:   esc_byte = 8'h08;
            8'h72:   esc_byte = 8'h0D;
            8'h66:   esc_byte = 8'h0C;
            default: esc_byte = 8'h00;
        endcase
    end

    assign o_tready = !i_full;
    assign accept   = i_tvalid && o_tready;
    assign mode_eff = i_restart ? M_PLAIN : r_mode;
    assign acc_eff  = i_restart ? 16'h0000 : r_acc;
    assign cp       = {acc_eff[11:0], digit};

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        o_push = 1'b0;
        o_job  = '{cnt: 2'd1, kind: KIND_DATA, code: ERR_NONE,
                   b0: 8'h00, b1: 8'h00, b2: 8'h00};
        if (accept) begin
            n_mode = mode_eff;
            n_acc  = acc_eff;
            if (mode_eff == M_ERROR || mode_eff == M_DONE) begin
                o_push = 1'b0;
            end else if (i_byte == 8'h00) begin
                o_push     = 1'b1;
                o_job.kind = KIND_ERROR;
                o_job.code = ERR_ZERO;
                n_mode     = M_ERROR;
            end else begin
                case (mode_eff)
                    M_PLAIN: begin
                        if (i_byte == 8'h22) begin
                            o_push     = 1'b1;
                            o_job.kind = KIND_END;
                            n_mode     = M_DONE;
                        end else if (i_byte == 8'h5C) begin
                            n_mode = M_ESC;
                        end else begin
                            o_push   = 1'b1;
                            o_job.b0 = i_byte;
                        end
                    end
                    M_ESC: begin
                        o_push = 1'b1;
                        if (i_byte == 8'h75) begin
                            o_push = 1'b0;
                            n_acc  = 16'h0000;
                            n_mode = M_HEX1;
                        end else if (esc_byte == 8'h00) begin
                            o_job.kind = KIND_ERROR;
                            o_job.code = ERR_ESCAPE;
                            n_mode     = M_ERROR;
                        end else begin
                            o_job.b0 = esc_byte;
                            n_mode   = M_PLAIN;
                        end
                    end
                    M_HEX1, M_HEX2, M_HEX3, M_HEX4: begin
                        if (!is_hex) begin
                            o_push     = 1'b1;
                            o_job.kind = KIND_ERROR;
                            o_job.code = ERR_BAD_HEX;
                            n_mode     = M_ERROR;
                        end else begin
                            n_acc = cp;
                            case (mode_eff)
                                M_HEX1:  n_mode = M_HEX2;
                                M_HEX2:  n_mode = M_HEX3;
                                M_HEX3:  n_mode = M_HEX4;
                                default: n_mode = M_PLAIN;
                            endcase
                            if (mode_eff == M_HEX4) begin
                                o_push = 1'b1;
                                if (cp[15:11] != 5'd0) begin
                                    o_job.cnt = 2'd3;
                                    o_job.b0  = {4'hE, cp[15:12]};
                                    o_job.b1  = {2'b10, cp[11:6]};
                                    o_job.b2  = {2'b10, cp[5:0]};
                                end else if (cp[10:7] != 4'd0) begin
                                    o_job.cnt = 2'd2;
                                    o_job.b0  = {3'b110, cp[10:6]};
                                    o_job.b1  = {2'b10, cp[5:0]};
                                end else begin
                                    o_job.b0  = cp[7:0];
                                end
                            end
                        end
                    end
                    default: begin
                        n_mode = M_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_PLAIN;
            r_acc  <= 16'h0000;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/jsu_fifo.sv -----
// Job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module jsu_fifo #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  jsu_pkg::t_job    i_job,
    output logic             o_full,
    output logic             o_valid,
    output jsu_pkg::t_job    o_job,
    input  wire              i_pop
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/jsu_back.sv -----
// Back end: walks each queued job and issues its results one per cycle while i_tready allows.
`timescale 1ns / 1ps
`default_nettype none
module jsu_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_job_valid,
    input  jsu_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_tvalid,
    input  wire              i_tready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte,
    output logic [1:0]       o_code,
    output logic             o_last
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx, n_idx;
    t_kind      r_kind;
    logic [7:0] r_byte, sel_byte;
    logic [1:0] r_code;
    logic       r_last;
    logic       advance, load, job_last;

    assign advance  = !r_valid || i_tready;
    assign load     = advance && i_job_valid;
    assign job_last = (r_idx == 2'(i_job.cnt - 2'd1));
    assign o_pop    = load && job_last;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_job.b0;
            2'd1:    sel_byte = i_job.b1;
            default: sel_byte = i_job.b2;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = job_last ? 2'd0 : 2'(r_idx + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (advance) begin
                r_valid <= i_job_valid;
            end
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_job.kind;
            r_byte <= sel_byte;
            r_code <= i_job.code;
            r_last <= job_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_kind   = r_kind;
    assign o_byte   = r_byte;
    assign o_code   = r_code;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    a_data_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_DATA |-> r_code == ERR_NONE)
        else $error("data result carries an error code");
    a_ctrl_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind != KIND_DATA |-> r_byte == 8'h00 && r_last)
        else $error("end or error result not a lone zero-byte result");
    a_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> i_job_valid && i_job.cnt > r_idx)
        else $error("sequencer inside a job with no job at the queue head");
`endif

endmodule
`default_nettype wire

// ----- rtl/json_string_unescape_utf8.sv -----
// Top level of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one content byte of a JSON string per cycle and emits decoded bytes,
// an end result at the closing quote, or an error result. Every input byte is
// classified in the cycle it is accepted; the results it causes (zero to three)
// are queued as one job in a QUEUE_DEPTH-entry queue and issued by the output
// sequencer at one result per cycle while m_axis_tready is high. A \u escape
// whose code point needs three UTF-8 bytes holds the output for three results,
// so sustained throughput is one result per cycle and input stalls only when
// the queue fills. A result passes through the queue and the output register.
// Assert tuser with the first byte of each new string to clear state.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire  [0:0]  s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast    // last_of_run
);
    import jsu_pkg::*;

    t_job       push_job, head_job;
    logic       push, full, head_valid, pop;
    logic [7:0] out_byte;
    logic [1:0] out_code;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_restart (s_axis_tuser[0]),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_byte      (out_byte),
        .o_code      (out_code),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b000000, out_code, out_byte};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps
module tb;
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        ST_TEXT, ST_BSLASH, ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4, ST_FAILED, ST_CLOSED
    } t_scan_state;

    typedef enum int {
        FLAW_NONE, FLAW_ZERO, FLAW_BAD_ESCAPE, FLAW_BAD_HEX, FLAW_OPEN_ESCAPE, FLAW_CUT
    } t_flaw;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [1:0] code;
        logic       last;
    } t_decoded;

    localparam logic [7:0] ESC_LETTERS [8] = '{"/", "\\", "\"", "t", "n", "b", "r", "f"};
    localparam logic [15:0] CP_EDGES [6] = '{16'h0000, 16'h007F, 16'h0080,
                                             16'h07FF, 16'h0800, 16'hFFFF};

    function automatic bit is_hex_digit(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    class unescape_scoreboard;
        t_decoded    expected_q[$];
        t_decoded    burst[$];
        t_scan_state state;
        logic [15:0] cp_acc;
        int          errors;
        int          checked;
        int          ends;
        int          faults;
        int          wide;

        function new();
            state = ST_TEXT;
            cp_acc = '0;
            errors = 0;
            checked = 0;
            ends = 0;
            faults = 0;
            wide = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add(t_kind k, logic [7:0] b, logic [1:0] code);
            t_decoded entry;
            entry = '{k, b, code, 1'b0};
            burst.insert(burst.size(), entry);
        endfunction

        // Predict the results of one accepted byte; return 0 when the byte is dropped.
        function bit note_byte(logic [7:0] c, bit restart);
            logic [3:0]  nib;
            logic [15:0] cp;
            logic [7:0]  mapped;
            burst.delete();
            if (restart) begin
                state = ST_TEXT;
                cp_acc = '0;
            end
            if (state == ST_FAILED || state == ST_CLOSED) return 1'b0;
            if (c == 8'h00) begin
                add(KIND_ERROR, 8'h00, ERR_ZERO);
                state = ST_FAILED;
            end else if (state == ST_TEXT) begin
                if (c == "\"") begin
                    add(KIND_END, 8'h00, ERR_NONE);
                    state = ST_CLOSED;
                end else if (c == "\\") begin
                    state = ST_BSLASH;
                end else begin
                    add(KIND_DATA, c, ERR_NONE);
                end
            end else if (state == ST_BSLASH) begin
                case (c)
                    "/":     mapped = "/";
                    "\\":    mapped = "\\";
                    "\"":    mapped = "\"";
                    "t":     mapped = 8'h09;
                    "n":     mapped = 8'h0A;
                    "b":     mapped = 8'h08;
                    "r":     mapped = 8'h0D;
                    "f":     mapped = 8'h0C;
                    default: mapped = 8'h00;
                endcase
                if (c == "u") begin
                    cp_acc = '0;
                    state = ST_HEX1;
                end else if (mapped == 8'h00) begin
                    add(KIND_ERROR, 8'h00, ERR_ESCAPE);
                    state = ST_FAILED;
                end else begin
                    add(KIND_DATA, mapped, ERR_NONE);
                    state = ST_TEXT;
                end
            end else if (!is_hex_digit(c)) begin
                add(KIND_ERROR, 8'h00, ERR_BAD_HEX);
                state = ST_FAILED;
            end else begin
                nib = (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
                cp = {cp_acc[11:0], nib};
                cp_acc = cp;
                if (state == ST_HEX4) begin
                    if (cp > 16'h07FF) begin
                        add(KIND_DATA, 8'hE0 | {4'h0, cp[15:12]}, ERR_NONE);
                        add(KIND_DATA, 8'h80 | {2'b00, cp[11:6]}, ERR_NONE);
                        add(KIND_DATA, 8'h80 | {2'b00, cp[5:0]}, ERR_NONE);
                        wide++;
                    end else if (cp > 16'h007F) begin
                        add(KIND_DATA, 8'hC0 | {3'b000, cp[10:6]}, ERR_NONE);
                        add(KIND_DATA, 8'h80 | {2'b00, cp[5:0]}, ERR_NONE);
                    end else begin
                        add(KIND_DATA, cp[7:0], ERR_NONE);
                    end
                    state = ST_TEXT;
                end else begin
                    state = t_scan_state'(state + 3'd1);
                end
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) expected_q.insert(expected_q.size(), burst[i]);
            return 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic [1:0] code,
                                   logic last);
            t_decoded want;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind=%0d byte=%02h code=%0d last=%0b",
                             kind, data, code, last);
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind || data !== want.data || code !== want.code ||
                last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected kind=%0d byte=%02h code=%0d last=%0b",
                             want.kind, want.data, want.code, want.last);
                    $display("          got      kind=%0d byte=%02h code=%0d last=%0b",
                             kind, data, code, last);
                end
            end else if (kind == KIND_END) begin
                ends++;
            end else if (kind == KIND_ERROR) begin
                faults++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] in_byte
    logic [0:0]  s_axis_tuser;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // [7:0] out_byte, [9:8] error_code
    logic [1:0]  m_axis_tuser;   // [1:0] out_kind
    logic        m_axis_tlast;

    unescape_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int bytes_used;
    int strings_sent;
    bit new_string;

    json_string_unescape_utf8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "A" : "a";
        return (n < 4'd10) ? "0" + {4'h0, n} : base + {4'h0, n} - 8'd10;
    endfunction

    task automatic feed_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= new_string;
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.note_byte(b, new_string)) bytes_used++;
        new_string = 1'b0;
    endtask

    task automatic feed_text(string s);
        for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
    endtask

    task automatic feed_hex_digits(int n);
        repeat (n) feed_byte(hex_char(4'($urandom_range(0, 15))));
    endtask

    // Hold the sender until every predicted result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic feed_random_string();
        int          ntok;
        int          sel;
        t_flaw       flaw;
        int          flaw_at;
        logic [15:0] cp;
        logic [7:0]  c;
        new_string = 1'b1;
        strings_sent++;
        ntok = $urandom_range(0, 10);
        flaw = ($urandom_range(99) < 22) ? t_flaw'($urandom_range(1, 5)) : FLAW_NONE;
        flaw_at = $urandom_range(0, ntok);
        for (int i = 0; i < ntok; i++) begin
            if (flaw != FLAW_NONE && i == flaw_at) break;
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                do c = 8'($urandom_range(1, 255)); while (c == "\"" || c == "\\");
                feed_byte(c);
            end else if (sel < 7) begin
                feed_byte("\\");
                feed_byte(ESC_LETTERS[$urandom_range(0, 7)]);
            end else begin
                sel = $urandom_range(0, 9);
                if (sel == 0) cp = CP_EDGES[$urandom_range(0, 5)];
                else if (sel < 4) cp = 16'($urandom_range(0, 16'h007F));
                else if (sel < 7) cp = 16'($urandom_range(16'h0080, 16'h07FF));
                else cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                feed_text("\\u");
                for (int k = 3; k >= 0; k--) feed_byte(hex_char(cp[k*4 +: 4]));
            end
        end
        case (flaw)
            FLAW_NONE: feed_byte("\"");
            FLAW_ZERO: begin
                sel = $urandom_range(0, 2);
                if (sel >= 1) feed_byte("\\");
                if (sel == 2) begin
                    feed_byte("u");
                    feed_hex_digits($urandom_range(0, 3));
                end
                feed_byte(8'h00);
            end
            FLAW_BAD_ESCAPE: begin
                feed_byte("\\");
                do c = 8'($urandom_range(1, 255));
                while (c inside {"/", "\\", "\"", "t", "n", "b", "r", "f", "u"});
                feed_byte(c);
            end
            FLAW_BAD_HEX: begin
                feed_text("\\u");
                feed_hex_digits($urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0) c = "\"";
                else do c = 8'($urandom_range(1, 255)); while (is_hex_digit(c));
                feed_byte(c);
            end
            FLAW_OPEN_ESCAPE: begin
                feed_byte("\\");
                if ($urandom_range(0, 1)) begin
                    feed_byte("u");
                    feed_hex_digits($urandom_range(0, 3));
                end
            end
            default: ;
        endcase
        // bytes past the close or the error must be dropped
        if (flaw inside {FLAW_NONE, FLAW_ZERO, FLAW_BAD_ESCAPE, FLAW_BAD_HEX} &&
            $urandom_range(99) < 30)
            repeat ($urandom_range(1, 3)) feed_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int start;
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        bytes_used = 0;
        strings_sent = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        new_string = 1'b1;
        feed_byte(8'hFF);
        feed_byte(8'h01);
        feed_text("\\u0080\\uFFff\"x");
        new_string = 1'b1;
        feed_byte("\\");
        feed_byte(8'h00);
        feed_byte("y");
        new_string = 1'b1;
        feed_text("\\u\"");
        new_string = 1'b1;
        feed_text("\\q");
        new_string = 1'b1;
        feed_byte(8'h00);
        strings_sent += 5;
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            start = bytes_used;
            while (bytes_used - start < 90) feed_random_string();
            drain();
        end

        $display("run covered %0d strings, %0d decoded input bytes, %0d results checked",
                 strings_sent, bytes_used, sb.checked);
        $display("  including %0d string ends, %0d errors, %0d three-byte code points",
                 sb.ends, sb.faults, sb.wide);
        if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end
endmodule
